// ===== rtl/bhte_pkg.sv =====
// Shared types, constants and helpers for the bucketed hash table engine.
// No dependencies; every other file imports this package.
package bhte_pkg;

  localparam int unsigned MaxBuckets = 256;
  localparam int unsigned MaxWays    = 8;
  localparam int unsigned HashBytes  = 8;
  localparam int unsigned TableDepth = MaxBuckets * MaxWays;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned IdxW    = 11;
  localparam int unsigned BucketW = 8;
  localparam int unsigned WayW    = 3;
  localparam int unsigned RemW    = 8;
  localparam int unsigned StepW   = 7;

  // request kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  // unused kind: changes nothing and answers with an empty result
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // configuration register indices
  localparam logic [1:0] CFG_HASH_LEN     = 2'd0;
  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE  = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [IdxW-1:0]    slot_index;
    logic [BucketW-1:0] bucket;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [StepW-1:0]  steps;
    logic [KeyW-1:0]   dividend;
    logic [8:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] quotient;
    logic [RemW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] addr;
    logic [KeyW-1:0] wdata;
  } tbl_req_t;

  // Low n bytes set; eight or more selects the whole key.
  function automatic logic [KeyW-1:0] byte_mask(input logic [3:0] n);
    logic [KeyW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/bhte_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on bhte_pkg for the request and response structs.
module bhte_div import bhte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [KeyW-1:0]  dvd_q;
  logic [RemW-1:0]  rem_q;
  logic [IdxW-1:0]  quo_q;
  logic [StepW-1:0] cnt_q;
  logic [8:0]       dvs_q;
  logic             busy_q;
  logic             done_q;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  // hold the divisor from the start; the request lines move on after it
  assign trial = {rem_q, dvd_q[KeyW-1]};
  assign ge    = trial >= dvs_q;
  assign diff  = trial - dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[KeyW-2:0], 1'b0};
        rem_q <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
        quo_q <= {quo_q[IdxW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/bhte_table.sv =====
// Key store: single-port memory with registered read and a clearing sweep
// after reset. Depends on bhte_pkg for the request struct.
module bhte_table import bhte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_req_t        req_i,
  output logic [KeyW-1:0] rdata_o,
  output logic            clearing_o
);

  logic [KeyW-1:0] mem [TableDepth];
  logic [IdxW:0]   clr_q;
  logic [KeyW-1:0] rdata_q;

  assign clearing_o = !clr_q[IdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_o) begin
      mem[clr_q[IdxW-1:0]] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bucketed_hash_table_engine_core.sv =====
// Bucketed hash table engine, top level. Uses bhte_pkg, bhte_div, bhte_table.
// Lookup / find-free: the divider maps the masked key to a bucket, then one slot read
// per cycle scans its ways in use; the next transfer is taken while the result is on offer.
// Write: the divider splits the index by the ways in use into bucket and slot, then stores.
// One item in flight; a finished result waits in the output register.
// Reset restores 8 / 256 / 8 and starts a sweep that zeroes the store.
module bucketed_hash_table_engine_core import bhte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [3:0] hash_len_q;
  logic [8:0] bucket_count_q;
  logic [3:0] ways_q;

  // per-item working registers
  logic [1:0]         kind_q;
  logic [KeyW-1:0]    key_q;
  logic [IdxW-1:0]    idx_q;
  logic [BucketW-1:0] bucket_q;
  logic [3:0]         way_q;
  logic [WayW-1:0]    cmp_way_q;
  logic               cmp_valid_q;
  out_item_t          res_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic [3:0]      eff_len;
  logic [8:0]      eff_nb;
  logic [3:0]      eff_ways;
  logic [KeyW-1:0] mask;
  logic            clearing;
  logic            in_fire;
  logic            hit;
  logic            wr_ok;
  logic [KeyW-1:0] rdata;
  logic [KeyW-1:0] rd_masked;
  logic [11:0]     bucket_base;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  tbl_req_t        tbl_req;

  // Clamp the configuration to the supported ranges.
  assign eff_len  = (hash_len_q > 4'(HashBytes)) ? 4'(HashBytes) : hash_len_q;
  assign eff_nb   = (bucket_count_q == '0) ? 9'd1 :
                    (bucket_count_q > 9'(MaxBuckets)) ? 9'(MaxBuckets) : bucket_count_q;
  assign eff_ways = (ways_q == '0) ? 4'd1 :
                    (ways_q > 4'(MaxWays)) ? 4'(MaxWays) : ways_q;
  assign mask     = byte_mask(eff_len);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && !clearing;
  assign in_fire     = in_valid_i && in_ready_o;

  // Lookups divide the masked key over all 64 bits; writes divide the
  // index, placed at the top of the dividend, over its 11 bits.
  always_comb begin
    div_req.start    = in_fire && (in_data_i.kind != KIND_SPARE);
    div_req.divisor  = eff_nb;
    div_req.steps    = StepW'(KeyW);
    div_req.dividend = in_data_i.key & mask;
    if (in_data_i.kind == KIND_WRITE) begin
      div_req.divisor  = {5'd0, eff_ways};
      div_req.steps    = StepW'(IdxW);
      div_req.dividend = {in_data_i.entry_index, (KeyW-IdxW)'(0)};
    end
  end

  bhte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A write lands once the quotient shows the bucket is in use.
  assign wr_ok = (state_q == ST_DIV) && div_rsp.done && (kind_q == KIND_WRITE) &&
                 (div_rsp.quotient < {2'd0, eff_nb});

  always_comb begin
    tbl_req.rd_en = (state_q == ST_SCAN);
    tbl_req.wr_en = wr_ok;
    tbl_req.wdata = key_q;
    tbl_req.addr  = {bucket_q, way_q[WayW-1:0]};
    if (state_q == ST_DIV) begin
      tbl_req.addr = {div_rsp.quotient[BucketW-1:0], div_rsp.remainder[WayW-1:0]};
    end
  end

  bhte_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  // key_q already holds the masked key for lookups.
  assign rd_masked   = rdata & mask;
  assign hit         = (kind_q == KIND_LOOKUP) ? (rd_masked == key_q) : (rd_masked == '0);
  assign bucket_base = bucket_q * eff_ways;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      hash_len_q     <= 4'd8;
      bucket_count_q <= 9'd256;
      ways_q         <= 4'd8;
      out_valid_q    <= 1'b0;
      cmp_valid_q    <= 1'b0;
      way_q          <= '0;
      kind_q         <= KIND_LOOKUP;
      key_q          <= '0;
      idx_q          <= '0;
      bucket_q       <= '0;
      cmp_way_q      <= '0;
      res_q          <= '0;
      out_data_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_HASH_LEN:     hash_len_q     <= cfg_data_i[3:0];
          CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i;
          CFG_WAYS_IN_USE:  ways_q         <= cfg_data_i[3:0];
          default:          ;
        endcase
      end

      // load a finished result when the output register is free, else drop
      // the result once taken
      if ((state_q == ST_RESULT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q <= in_data_i.kind;
            idx_q  <= in_data_i.entry_index;
            key_q  <= (in_data_i.kind == KIND_WRITE) ? in_data_i.key
                                                     : (in_data_i.key & mask);
            res_q  <= '0;
            state_q <= (in_data_i.kind == KIND_SPARE) ? ST_RESULT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (kind_q == KIND_WRITE) begin
              if (wr_ok) begin
                res_q.found      <= 1'b1;
                res_q.slot_index <= idx_q;
                res_q.bucket     <= div_rsp.quotient[BucketW-1:0];
              end
              state_q <= ST_RESULT;
            end else begin
              bucket_q    <= div_rsp.remainder;
              res_q.bucket <= div_rsp.remainder;
              way_q       <= '0;
              cmp_valid_q <= 1'b0;
              state_q     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue the next slot read while checking the previous one
          way_q       <= way_q + 1'b1;
          cmp_way_q   <= way_q[WayW-1:0];
          cmp_valid_q <= 1'b1;
          if (cmp_valid_q) begin
            if (hit) begin
              res_q.found      <= 1'b1;
              res_q.slot_index <= bucket_base[IdxW-1:0] + {8'd0, cmp_way_q};
              state_q          <= ST_RESULT;
            end else if ({1'b0, cmp_way_q} == eff_ways - 1'b1) begin
              state_q <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_data_q  <= res_q;
            cmp_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // every transfer starts work, so the engine leaves idle
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("transfer taken but engine stayed idle");

  // the divider only finishes while the engine waits on it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  // no store write may collide with the clearing sweep
  a_no_write_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.wr_en |-> !clearing)
    else $error("store written during clearing sweep");

  // the scan never checks a slot beyond the ways in use
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_valid_q) |-> ({1'b0, cmp_way_q} < eff_ways))
    else $error("scan ran past the last slot in use");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for bucketed_hash_table_engine_core: directed rows, then
// random phases under changing register settings, checked against a shadow table.
// Depends on bhte_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench import bhte_pkg::*; ();

  // register index that the package leaves unnamed
  localparam logic [1:0] CFG_NONE   = 2'd3;

  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 108;
  // Longest quiet spell: several times the worst correct gap, which is the store
  // sweep after reset or one item plus its stalls.
  localparam int unsigned IdleLimit     = 20000;
  localparam int unsigned TailCycles    = 100;

  typedef struct {
    bit         is_cfg;
    bit         has_want;
    in_item_t   req;
    out_item_t  want;
    logic [1:0] reg_index;
    logic [8:0] reg_value;
  } drill_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  in_item_t   req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  out_item_t  rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // shadow of the block: stored keys and the three registers
  logic [KeyW-1:0] shadow_keys [TableDepth];
  logic [3:0]      shadow_hash_len = 4'd8;
  logic [8:0]      shadow_bucket_count = 9'd256;
  logic [3:0]      shadow_ways = 4'd8;

  out_item_t       expected_results [$];
  logic [KeyW-1:0] recent_keys [$];
  drill_row_t      drill_rows [$];
  int unsigned     mismatch_count = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     w_left = 0;
  bit              calm = 1'b1;

  bucketed_hash_table_engine_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_data_o  (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  function automatic logic [KeyW-1:0] bytes_mask(int unsigned n);
    if (n >= 8) begin
      return '1;
    end
    if (n == 0) begin
      return '0;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Clamp the registers the way the block does: length to HashBytes, zero
  // buckets or ways to one, oversized values to the table's limits.
  function automatic logic [KeyW-1:0] used_mask();
    return bytes_mask((shadow_hash_len > HashBytes) ? HashBytes : shadow_hash_len);
  endfunction

  function automatic int unsigned used_buckets();
    if (shadow_bucket_count == 0) begin
      return 1;
    end
    return (shadow_bucket_count > MaxBuckets) ? MaxBuckets : shadow_bucket_count;
  endfunction

  function automatic int unsigned used_ways();
    if (shadow_ways == 0) begin
      return 1;
    end
    return (shadow_ways > MaxWays) ? MaxWays : shadow_ways;
  endfunction

  function automatic logic [BucketW-1:0] bucket_of(logic [KeyW-1:0] key);
    logic [KeyW-1:0] divisor;
    divisor = 64'(used_buckets());
    return BucketW'((key & used_mask()) % divisor);
  endfunction

  // Work out the result of one request and apply any write to the shadow table.
  function automatic out_item_t resolve_request(in_item_t item);
    out_item_t       res;
    logic [KeyW-1:0] mask;
    logic [KeyW-1:0] kbits;
    logic [KeyW-1:0] held;
    int unsigned     ways;
    int unsigned     bi;
    int unsigned     b;
    bit              hit;
    res = '0;
    ways = used_ways();
    mask = used_mask();
    case (item.kind)
      KIND_LOOKUP, KIND_FREE: begin
        kbits = item.key & mask;
        res.bucket = bucket_of(item.key);
        bi = res.bucket;
        // scan the bucket in slot order, stop at the first hit
        for (int i = 0; i < ways; i++) begin
          held = shadow_keys[bi * MaxWays + i] & mask;
          hit = (item.kind == KIND_LOOKUP) ? (held == kbits) : (held == '0);
          if (hit) begin
            res.found = 1'b1;
            res.slot_index = IdxW'(bi * ways + i);
            break;
          end
        end
      end
      KIND_WRITE: begin
        b = item.entry_index / ways;
        // drop writes that land beyond the buckets in use
        if (b < used_buckets()) begin
          shadow_keys[b * MaxWays + item.entry_index % ways] = item.key & bytes_mask(HashBytes);
          res.found = 1'b1;
          res.slot_index = item.entry_index;
          res.bucket = BucketW'(b);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void add_req(logic [1:0] kind, logic [KeyW-1:0] key,
                                  logic [IdxW-1:0] idx, bit has_want, logic found,
                                  logic [IdxW-1:0] slot, logic [BucketW-1:0] bkt);
    drill_row_t row;
    row = '{default: '0};
    row.req.kind = kind;
    row.req.key = key;
    row.req.entry_index = idx;
    row.has_want = has_want;
    row.want.found = found;
    row.want.slot_index = slot;
    row.want.bucket = bkt;
    drill_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [1:0] index, logic [8:0] value);
    drill_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_index = index;
    row.reg_value = value;
    drill_rows.push_back(row);
  endfunction

  // A slot inside the key's own bucket, so that later lookups can find it.
  function automatic logic [IdxW-1:0] home_index(logic [KeyW-1:0] key);
    return IdxW'(bucket_of(key) * used_ways() + $urandom_range(0, used_ways() - 1));
  endfunction

  // Mostly well-formed traffic: store keys in their home bucket, look them up
  // again with junk above the hashed bytes, hunt for free slots; the rest is
  // misses, writes anywhere (some outside the buckets) and the spare kind.
  function automatic in_item_t next_random_request();
    in_item_t        item;
    logic [KeyW-1:0] base;
    int unsigned     pick;
    item.kind = KIND_LOOKUP;
    item.key = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: item.key = '1;
      1: item.key = {56'd0, item.key[7:0]};
      default: begin
      end
    endcase
    item.entry_index = IdxW'($urandom_range(0, TableDepth - 1));
    base = item.key;
    if (recent_keys.size() != 0) begin
      base = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      item.kind = KIND_WRITE;
      if (pick < 31) begin
        item.entry_index = home_index((pick < 4) ? base : item.key);
      end
      if (pick < 4) begin
        // zero a slot that probably holds a key, so it counts as free again
        item.key = '0;
      end else begin
        recent_keys.push_back(item.key);
        if (recent_keys.size() > 64) begin
          void'(recent_keys.pop_front());
        end
      end
    end else if (pick < 65) begin
      item.key = base ^ ({$urandom, $urandom} & ~used_mask());
    end else if (pick < 85) begin
      item.kind = KIND_FREE;
      if (pick < 75) begin
        item.key = base;
      end
    end else if (pick >= 95) begin
      item.kind = KIND_SPARE;
    end
    return item;
  endfunction

  // Present one request after a random gap and hold it until the transfer;
  // leave valid high so a back-to-back request needs no second assignment.
  task automatic send_request(input in_item_t item, input bit has_want,
                              input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = draw_wait();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    predicted = resolve_request(item);
    expected_results.push_back(has_want ? want : predicted);
  endtask

  // Drop the request line and hold until every outstanding result is back.
  task automatic wait_for_idle();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Valid stays high on return; the caller drops it after the last write.
  task automatic write_register(input logic [1:0] index, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_HASH_LEN:     shadow_hash_len = value[3:0];
      CFG_BUCKET_COUNT: shadow_bucket_count = value;
      CFG_WAYS_IN_USE:  shadow_ways = value[3:0];
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    if (mismatch_count < 10) begin
      $display("mismatch (%0s) at %0t: want found=%0b slot=%0d bucket=%0d", what, $time,
               want.found, want.slot_index, want.bucket);
      $display("  got found=%0b slot=%0d bucket=%0d", got.found, got.slot_index,
               got.bucket);
    end
    mismatch_count++;
  endtask

  // Directed rows at reset settings first; the expected value is typed in where
  // it is plain: an empty table, the extreme slot, zero hash length, clamping.
  function automatic void load_drill_rows();
    logic [KeyW-1:0] top_bit;
    top_bit = 64'h8000_0000_0000_0000;
    add_req(KIND_LOOKUP, '0, '0, 1, 1'b1, 11'd0, 8'd0);        // zero key hits empty slot
    add_req(KIND_LOOKUP, 64'h1234, '0, 1, 1'b0, 11'd0, 8'h34); // miss keeps the bucket
    add_req(KIND_FREE, 64'h5, '0, 1, 1'b1, 11'd40, 8'd5);
    add_req(KIND_SPARE, '1, '1, 1, 1'b0, 11'd0, 8'd0);
    add_req(KIND_WRITE, '1, '1, 1, 1'b1, 11'd2047, 8'd255);    // last slot of last bucket
    add_req(KIND_LOOKUP, '1, '0, 1, 1'b1, 11'd2047, 8'd255);
    add_req(KIND_FREE, '1, '0, 1, 1'b1, 11'd2040, 8'd255);
    add_req(KIND_WRITE, top_bit, '0, 1, 1'b1, 11'd0, 8'd0);
    add_req(KIND_LOOKUP, top_bit, '0, 1, 1'b1, 11'd0, 8'd0);
    add_req(KIND_LOOKUP, '0, '0, 1, 1'b1, 11'd1, 8'd0);        // slot 0 taken, slot 1 empty
    // zero hash length: bucket 0, first slot matches anything and is free
    add_reg(CFG_HASH_LEN, 9'd0);
    add_req(KIND_LOOKUP, '1, '0, 1, 1'b1, 11'd0, 8'd0);
    add_req(KIND_FREE, 64'h1234, '0, 1, 1'b1, 11'd0, 8'd0);
    // oversized length, zero buckets and zero ways all clamp; spare index ignored
    add_reg(CFG_HASH_LEN, 9'd15);
    add_reg(CFG_BUCKET_COUNT, 9'd0);
    add_reg(CFG_WAYS_IN_USE, 9'd0);
    add_reg(CFG_NONE, 9'h1FF);
    add_req(KIND_LOOKUP, top_bit, '0, 1, 1'b1, 11'd0, 8'd0);
    add_req(KIND_WRITE, 64'h55, 11'd1, 1, 1'b0, 11'd0, 8'd0);  // outside the one bucket
    add_req(KIND_WRITE, 64'hAA, 11'd0, 1, 1'b1, 11'd0, 8'd0);
    // oversized buckets and ways, three-byte hash
    add_reg(CFG_BUCKET_COUNT, 9'd511);
    add_reg(CFG_WAYS_IN_USE, 9'd15);
    add_reg(CFG_HASH_LEN, 9'd3);
    add_req(KIND_WRITE, 64'hA5A5_5A5A_0000_0102, 11'd19, 0, 1'b0, '0, '0);
    add_req(KIND_LOOKUP, 64'hFFFF_FFFF_FF00_0102, '0, 0, 1'b0, '0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    drill_row_t row;
    logic [3:0] hl;
    logic [8:0] bc;
    logic [3:0] wy;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
    end
    load_drill_rows();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; drain before any register write so the block is idle.
    for (int i = 0; i < drill_rows.size(); i++) begin
      row = drill_rows[i];
      if (row.is_cfg) begin
        wait_for_idle();
        write_register(row.reg_index, row.reg_value);
        if (i + 1 == drill_rows.size() || !drill_rows[i + 1].is_cfg) begin
          cfg_valid <= 1'b0;
        end
      end else begin
        send_request(row.req, row.has_want, row.want);
      end
    end

    // Random phases: extremes first, then drawn settings, mostly few buckets
    // so that buckets fill up and find-free starts to fail.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_for_idle();
      calm = (p % 5 == 0);
      case (p)
        0: begin hl = 4'd8;  bc = 9'd256; wy = 4'd8;  end
        1: begin hl = 4'd1;  bc = 9'd1;   wy = 4'd1;  end
        2: begin hl = 4'd0;  bc = 9'd511; wy = 4'd15; end
        3: begin hl = 4'd15; bc = 9'd0;   wy = 4'd0;  end
        4: begin hl = 4'd2;  bc = 9'd3;   wy = 4'd5;  end
        default: begin
          hl = 4'($urandom_range(0, 15));
          bc = 9'($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 511));
          wy = 4'($urandom_range(0, 15));
        end
      endcase
      write_register(CFG_HASH_LEN, {5'd0, hl});
      write_register(CFG_BUCKET_COUNT, bc);
      write_register(CFG_WAYS_IN_USE, {5'd0, wy});
      cfg_valid <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_request(next_random_request(), 1'b0, '0);
      end
    end

    // Drain, then give stray results time to show up.
    wait_for_idle();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: after each transfer draw a wait, then raise ready once the
  // next result has been on offer that long. A zero wait keeps ready high.
  always @(posedge clk) begin : result_sink
    int unsigned w;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      w = draw_wait();
      rsp_ready <= (w == 0);
      w_left = w;
    end else if (!rsp_ready && rsp_valid) begin
      if (w_left == 0) begin
        rsp_ready <= 1'b1;
      end else begin
        w_left = w_left - 1;
      end
    end
  end

  // Compare every result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("nothing outstanding", '0, rsp);
      end else begin
        want = expected_results.pop_front();
        if (rsp.found !== want.found || rsp.slot_index !== want.slot_index ||
            rsp.bucket !== want.bucket) begin
          report_mismatch("field differs", want, rsp);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
